FILE: rtl/core/pip_pkg.sv
package pip_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int MIN_FENCE    = 3;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int CNT_W        = 5;
    localparam int LAT_W        = 31;
    localparam int LON_W        = 32;
    localparam int PROD_W       = (LAT_W + 1) + (LON_W + 1);

    localparam int IN_IDX_LSB   = 0;
    localparam int IN_LAT_LSB   = IN_IDX_LSB + 4;
    localparam int IN_LON_LSB   = IN_LAT_LSB + LAT_W;
    localparam int IN_USED_W    = IN_LON_LSB + LON_W;
    localparam int IN_TDATA_W   = ((IN_USED_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W  = 8;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic signed [LAT_W-1:0] lat;
        logic signed [LON_W-1:0] lon;
    } vertex_t;

    typedef struct packed {
        logic mul_en;
        logic sel_rhs;
    } edge_ctrl_t;

    typedef struct packed {
        logic straddle;
        logic below;
    } edge_stat_t;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_LOAD  = 7'b0000010,
        ST_PREV  = 7'b0000100,
        ST_MUL_L = 7'b0001000,
        ST_MUL_R = 7'b0010000,
        ST_CMP   = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

endpackage

FILE: rtl/core/pip_vtx_mem.sv
module pip_vtx_mem (
    input  logic                           aclk,
    input  logic                           we,
    input  logic [pip_pkg::IDX_W-1:0]      waddr,
    input  pip_pkg::vertex_t               wdata,
    input  logic                           re,
    input  logic [pip_pkg::IDX_W-1:0]      raddr,
    output pip_pkg::vertex_t               rdata
);
    import pip_pkg::*;

    vertex_t mem [MAX_VERTICES];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/core/pip_edge_unit.sv
module pip_edge_unit (
    input  logic                aclk,
    input  pip_pkg::edge_ctrl_t ctrl,
    input  pip_pkg::vertex_t    pt,
    input  pip_pkg::vertex_t    cur,
    input  pip_pkg::vertex_t    prev,
    output pip_pkg::edge_stat_t stat
);
    import pip_pkg::*;

    logic signed [LAT_W:0]    da;
    logic signed [LAT_W:0]    db;
    logic signed [LON_W:0]    span;
    logic signed [LON_W:0]    dl;
    logic signed [LAT_W:0]    op_a;
    logic signed [LON_W:0]    op_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] lhs_reg;
    logic signed [LON_W-1:0]  pt_lon;
    logic signed [LON_W-1:0]  cur_lon;
    logic signed [LON_W-1:0]  prev_lon;

    assign pt_lon   = pt.lon;
    assign cur_lon  = cur.lon;
    assign prev_lon = prev.lon;

    assign da   = {pt.lat[LAT_W-1], pt.lat} - {cur.lat[LAT_W-1], cur.lat};
    assign db   = {prev.lat[LAT_W-1], prev.lat} - {cur.lat[LAT_W-1], cur.lat};
    assign span = {prev.lon[LON_W-1], prev.lon} - {cur.lon[LON_W-1], cur.lon};
    assign dl   = {pt.lon[LON_W-1], pt.lon} - {cur.lon[LON_W-1], cur.lon};

    // shared multiplier: lhs = da*span, then rhs = db*dl
    assign op_a = ctrl.sel_rhs ? db : da;
    assign op_b = ctrl.sel_rhs ? dl : span;
    assign prod = op_a * op_b;

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            prod_reg <= prod;
            if (ctrl.sel_rhs) begin
                lhs_reg <= prod_reg;
            end
        end
    end

    assign stat.straddle = (cur_lon > pt_lon) != (prev_lon > pt_lon);
    assign stat.below    = span[LON_W] ? (lhs_reg > prod_reg) : (lhs_reg < prod_reg);

endmodule

FILE: rtl/core/point_in_polygon_test_top.sv
// Point-in-polygon test, even-odd ray casting over a 16-entry vertex table.
// Input stream (s_*): s_tuser is the operation (0 writes a vertex, 1 queries
// a point); s_tdata carries the slot, latitude and longitude, degrees * 1e7.
// Result stream (m_*): one transaction per input transaction, carrying
// inside_res and fence_valid.
// Config channel (cfg_*): writes vertex_count; always ready. Write it only
// while the block is idle.
// Sequencing: a write, or a query with fewer than three vertices, goes
// straight to the output state after acceptance. A query over n vertices
// loads the table, then walks the edges on one shared 32x33 multiplier,
// two products and one compare per edge, and then writes the output.
// One transaction is in work at a time; s_tready is high only when idle.
// A finished result sits in the output register while the next input is
// taken; if the receiver stalls, the block holds the next result back and
// waits before going idle again.
// Reset clears vertex_count and the control state; table contents are
// undefined until written.
module point_in_polygon_test_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [3:0] vertex_index, [34:4] lat, [66:35] lon, [71:67] zero
    input  logic [pip_pkg::IN_TDATA_W-1:0]    s_tdata,
    // [0] operation
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [0] inside_res, [1] fence_valid, [7:2] zero
    output logic [pip_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pip_pkg::CNT_W-1:0]         cfg_data
);
    import pip_pkg::*;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     vertex_count_reg;
    logic [CNT_W-1:0]     n_sat;
    logic [CNT_W-1:0]     n_minus1;
    logic                 fence_ok;
    logic [IDX_W-1:0]     i_reg, i_next;
    logic                 inside_reg, inside_next;
    logic                 fence_reg, fence_next;
    vertex_t              pt_reg, pt_next;
    vertex_t              prev_reg, prev_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [1:0]           m_bits_reg, m_bits_next;
    logic                 s_accept;
    logic                 last_edge;
    vertex_t              in_vtx;
    logic [IDX_W-1:0]     in_idx;
    logic                 mem_we;
    logic                 mem_re;
    logic [IDX_W-1:0]     mem_raddr;
    vertex_t              rd_vtx;
    edge_ctrl_t           ectrl;
    edge_stat_t           estat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vertex_count_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            vertex_count_reg <= cfg_data;
        end
    end

    assign n_sat     = (vertex_count_reg > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES)
                                                                : vertex_count_reg;
    assign n_minus1  = n_sat - CNT_W'(1);
    assign fence_ok  = n_sat >= CNT_W'(MIN_FENCE);
    assign last_edge = ({1'b0, i_reg} == n_minus1);

    assign s_tready   = (state_reg == ST_IDLE);
    assign s_accept   = s_tvalid && s_tready;
    assign in_idx     = s_tdata[IN_IDX_LSB +: IDX_W];
    assign in_vtx.lat = s_tdata[IN_LAT_LSB +: LAT_W];
    assign in_vtx.lon = s_tdata[IN_LON_LSB +: LON_W];
    assign mem_we     = s_accept && (s_tuser == OP_WRITE);

    pip_vtx_mem u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (in_idx),
        .wdata (in_vtx),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (rd_vtx)
    );

    pip_edge_unit u_edge (
        .aclk (aclk),
        .ctrl (ectrl),
        .pt   (pt_reg),
        .cur  (rd_vtx),
        .prev (prev_reg),
        .stat (estat)
    );

    always_comb begin
        state_next    = state_reg;
        i_next        = i_reg;
        inside_next   = inside_reg;
        fence_next    = fence_reg;
        pt_next       = pt_reg;
        prev_next     = prev_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_bits_next   = m_bits_reg;
        mem_re        = 1'b0;
        mem_raddr     = i_reg;
        ectrl         = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    pt_next    = in_vtx;
                    fence_next = fence_ok;
                    if (s_tuser == OP_QUERY && fence_ok) begin
                        inside_next = 1'b0;
                        state_next  = ST_LOAD;
                    end else begin
                        inside_next = (s_tuser == OP_QUERY);
                        state_next  = ST_OUT;
                    end
                end
            end
            ST_LOAD: begin
                mem_re     = 1'b1;
                mem_raddr  = n_minus1[IDX_W-1:0];
                state_next = ST_PREV;
            end
            ST_PREV: begin
                prev_next  = rd_vtx;
                mem_re     = 1'b1;
                mem_raddr  = '0;
                i_next     = '0;
                state_next = ST_MUL_L;
            end
            ST_MUL_L: begin
                ectrl.mul_en = 1'b1;
                state_next   = ST_MUL_R;
            end
            ST_MUL_R: begin
                ectrl.mul_en  = 1'b1;
                ectrl.sel_rhs = 1'b1;
                state_next    = ST_CMP;
            end
            ST_CMP: begin
                if (estat.straddle && estat.below) begin
                    inside_next = !inside_reg;
                end
                prev_next = rd_vtx;
                if (last_edge) begin
                    state_next = ST_OUT;
                end else begin
                    i_next     = i_reg + IDX_W'(1);
                    mem_re     = 1'b1;
                    mem_raddr  = i_reg + IDX_W'(1);
                    state_next = ST_MUL_L;
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_bits_next   = {fence_reg, inside_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        i_reg      <= i_next;
        inside_reg <= inside_next;
        fence_reg  <= fence_next;
        pt_reg     <= pt_next;
        prev_reg   <= prev_next;
        m_bits_reg <= m_bits_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-2){1'b0}}, m_bits_reg};

    a_load_needs_fence: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOAD) |-> fence_ok)
        else $error("edge walk started without a valid fence");

    a_edge_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CMP) |-> ({1'b0, i_reg} < n_sat))
        else $error("edge index beyond vertex count");

    a_query_starts_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tuser == OP_QUERY && fence_ok) |=> (state_reg == ST_LOAD))
        else $error("query with valid fence did not start edge walk");

    a_out_delivers: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && (!m_tvalid_reg || m_tready))
        |=> (m_tvalid && state_reg == ST_IDLE))
        else $error("result not presented after finish");

endmodule
